// ===== src/smf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types, constants and helpers for the sigma mean filter.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int MaxRadius = 7;
  localparam int RingRows  = 2 * MaxRadius + 1;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight) + 1;
  localparam int RingW     = $clog2(RingRows);
  localparam int AddrW     = RingW + ColW;
  localparam int LineDepth = RingRows * MaxWidth;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_X_RADIUS     = 3'd2,
    REG_Y_RADIUS     = 3'd3,
    REG_MIN_COUNT    = 3'd4,
    REG_SIGMA        = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic {
    F_IDLE,
    F_EMIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CENTRE,
    B_SCAN,
    B_DRAIN,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [2:0]  x_radius;
    logic [2:0]  y_radius;
    logic [7:0]  min_count;
    logic [8:0]  sigma_threshold;
  } cfg_t;

  typedef struct packed {
    logic             is_write;
    logic [23:0]      pixel;
    logic [RingW-1:0] ring;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             last_of_run;
    logic             end_of_frame;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       end_of_frame;
  } res_t;

  // output (orow, ocol) has every pixel it needs once (irow, icol) is the next input
  function automatic logic out_ready(input logic [RowW-1:0] orow, input logic [ColW-1:0] ocol,
                                     input logic [RowW-1:0] irow, input logic [ColW-1:0] icol,
                                     input cfg_t c);
    logic [RowW:0] nr;
    logic [RowW:0] rl;
    logic [ColW:0] nc;
    logic [ColW:0] cl;
    nr = {1'b0, orow} + (RowW+1)'(c.y_radius);
    rl = (RowW+1)'(c.frame_height) - (RowW+1)'(1);
    if (nr > rl) nr = rl;
    nc = {1'b0, ocol} + (ColW+1)'(c.x_radius);
    cl = (ColW+1)'(c.frame_width) - (ColW+1)'(1);
    if (nc > cl) nc = cl;
    return ((RowW+1)'(orow) < (RowW+1)'(c.frame_height)) &&
           ((nr < {1'b0, irow}) || ((nr == {1'b0, irow}) && (nc < {1'b0, icol})));
  endfunction

endpackage

// ===== src/smf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_front
// Registers, frame counters and transaction intake; issues line store writes
// and window jobs to the job queue.
// ----------------------------------------------------------------------------
module smf_front import smf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output cfg_t        cfg,
  output logic        q_push,
  output job_t        q_entry,
  input  logic        q_full
);

  front_state_t     state, state_next;
  logic [ColW-1:0]  in_col, out_col;
  logic [RowW-1:0]  in_row, out_row;
  logic [RingW-1:0] in_ring, out_ring;
  logic [3:0]       n_out;
  logic             lim8;
  logic             accept, adv_in, adv_out;
  logic             eof_cur, rdy_cur, rdy_nxt;
  logic [ColW-1:0]  nout_col;
  logic [RowW-1:0]  nout_row;
  logic [RingW-1:0] nout_ring;
  logic [3:0]       lim;
  logic [10:0]      sat_size;
  logic [10:0]      sat_height;

  assign accept = push && !full;
  assign full   = (state != F_IDLE) || q_full;
  assign lim    = lim8 ? 4'd8 : 4'd1;

  assign eof_cur = ((RowW)'(out_row) == (RowW)'(cfg.frame_height - 11'd1)) &&
                   ({1'b0, out_col} == cfg.frame_width - 11'd1);
  assign rdy_cur = out_ready(out_row, out_col, in_row, in_col, cfg);

  always_comb begin
    nout_col  = out_col + ColW'(1);
    nout_row  = out_row;
    nout_ring = out_ring;
    if ({1'b0, out_col} + 11'd1 >= cfg.frame_width) begin
      nout_col  = '0;
      nout_row  = out_row + RowW'(1);
      nout_ring = (out_ring == RingW'(RingRows - 1)) ? '0 : out_ring + RingW'(1);
    end
    if (eof_cur) begin
      nout_col  = '0;
      nout_row  = '0;
      nout_ring = '0;
    end
    rdy_nxt = out_ready(nout_row, nout_col, eof_cur ? '0 : in_row, eof_cur ? '0 : in_col, cfg);
  end

  always_comb begin
    sat_size = cfg_data;
    if (cfg_data == 11'd0) sat_size = 11'd1;
    else if (cfg_data > 11'(MaxWidth)) sat_size = 11'(MaxWidth);
    sat_height = cfg_data;
    if (cfg_data == 11'd0) sat_height = 11'd1;
    else if (cfg_data > 11'(MaxHeight)) sat_height = 11'(MaxHeight);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    adv_in     = 1'b0;
    adv_out    = 1'b0;
    q_entry    = '0;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (command == CMD_PUSH) begin
            if ((RowW+1)'(in_row) < (RowW+1)'(cfg.frame_height)) begin
              q_push           = 1'b1;
              q_entry.is_write = 1'b1;
              q_entry.pixel    = {in_red, in_green, in_blue};
              q_entry.ring     = in_ring;
              q_entry.col      = in_col;
              adv_in           = 1'b1;
              state_next       = F_EMIT;
            end
          end else begin
            state_next = F_EMIT;
          end
        end
      end
      F_EMIT: begin
        if (!rdy_cur) begin
          state_next = F_IDLE;
        end else if (!q_full) begin
          q_push               = 1'b1;
          adv_out              = 1'b1;
          q_entry.ring         = out_ring;
          q_entry.col          = out_col;
          q_entry.row          = out_row;
          q_entry.end_of_frame = eof_cur;
          q_entry.last_of_run  = (n_out == lim - 4'd1) || !rdy_nxt;
          if (q_entry.last_of_run) state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= 11'(MaxWidth);
      cfg.frame_height    <= 11'(MaxHeight);
      cfg.x_radius        <= 3'd1;
      cfg.y_radius        <= 3'd1;
      cfg.min_count       <= 8'd1;
      cfg.sigma_threshold <= 9'd25;
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
      n_out    <= '0;
      lim8     <= 1'b0;
    end else begin
      if (accept) begin
        n_out <= '0;
        lim8  <= (command == CMD_PUSH);
      end
      if (adv_in) begin
        if ({1'b0, in_col} + 11'd1 >= cfg.frame_width) begin
          in_col  <= '0;
          in_row  <= in_row + RowW'(1);
          in_ring <= (in_ring == RingW'(RingRows - 1)) ? '0 : in_ring + RingW'(1);
        end else begin
          in_col <= in_col + ColW'(1);
        end
      end
      if (adv_out) begin
        n_out    <= n_out + 4'd1;
        out_col  <= nout_col;
        out_row  <= nout_row;
        out_ring <= nout_ring;
        if (eof_cur) begin
          in_col  <= '0;
          in_row  <= '0;
          in_ring <= '0;
        end
      end
      if (cfg_write) begin
        if (cfg_index <= REG_SIGMA) begin
          in_col   <= '0;
          in_row   <= '0;
          in_ring  <= '0;
          out_col  <= '0;
          out_row  <= '0;
          out_ring <= '0;
        end
        unique case (cfg_index)
          REG_FRAME_WIDTH:  cfg.frame_width     <= sat_size;
          REG_FRAME_HEIGHT: cfg.frame_height    <= sat_height;
          REG_X_RADIUS:     cfg.x_radius        <= cfg_data[2:0];
          REG_Y_RADIUS:     cfg.y_radius        <= cfg_data[2:0];
          REG_MIN_COUNT:    cfg.min_count       <= cfg_data[7:0];
          REG_SIGMA:        cfg.sigma_threshold <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/smf_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_job_queue
// Four-entry queue of writes and window jobs between front and back.
// ----------------------------------------------------------------------------
module smf_job_queue import smf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_entry,
  output logic q_full,
  input  logic rd,
  output logic q_empty,
  output job_t head
);

  job_t       entries [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign q_full  = (count == 3'd4);
  assign q_empty = (count == 3'd0);
  assign head    = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr && !q_full) entries[wptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !q_full) wptr <= wptr + 2'd1;
      if (rd && !q_empty) rptr <= rptr + 2'd1;
      count <= count + 3'(wr && !q_full) - 3'(rd && !q_empty);
    end
  end

endmodule

// ===== src/smf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_back
// Line store and window engine: one window pixel per cycle, then three
// restoring dividers in parallel.
// ----------------------------------------------------------------------------
module smf_back import smf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  job_t q_head,
  output logic q_pop,
  input  logic o_full,
  output logic o_push,
  output res_t o_entry
);

  logic [23:0]        line_store [LineDepth];
  logic [23:0]        rd_data;
  logic [AddrW-1:0]   rd_addr;
  back_state_t        state, state_next;
  job_t               job;
  logic signed [3:0]  dy, dx;
  logic               cen_v, scan_v;
  logic [7:0]         centre [3];
  logic [15:0]        sum [3];
  logic [15:0]        ssum [3];
  logic [7:0]         cnt [3];
  logic [15:0]        quo [3];
  logic [7:0]         rem [3];
  logic [7:0]         dvs [3];
  logic [2:0]         pass;
  logic [4:0]         step;
  logic [7:0]         neigh;
  logic [3:0]         xd, yd;
  logic signed [12:0] rs, dr, rg;
  logic [RowW-1:0]    r;
  logic signed [11:0] cs;
  logic [ColW-1:0]    c;
  logic               scan_last;

  assign xd    = {cfg.x_radius, 1'b1};
  assign yd    = {cfg.y_radius, 1'b1};
  assign neigh = xd * yd - 8'd1;

  // clamped window coordinates and their ring row
  always_comb begin
    rs = $signed({2'b00, job.row}) + 13'(dy);
    if (rs < 0) r = '0;
    else if (rs >= $signed({2'b00, cfg.frame_height})) r = RowW'(cfg.frame_height - 11'd1);
    else r = rs[RowW-1:0];
    dr = $signed({2'b00, r}) - $signed({2'b00, job.row});
    rg = $signed(13'(job.ring)) + dr;
    if (rg < 0) rg = rg + 13'(RingRows);
    else if (rg >= 13'(RingRows)) rg = rg - 13'(RingRows);
    cs = $signed({2'b00, job.col}) + 12'(dx);
    if (cs < 0) c = '0;
    else if (cs >= $signed({1'b0, cfg.frame_width})) c = ColW'(cfg.frame_width - 11'd1);
    else c = cs[ColW-1:0];
    rd_addr = (state == B_CENTRE) ? {job.ring, job.col} : {rg[RingW-1:0], c};
  end

  assign scan_last = (dx == $signed({1'b0, cfg.x_radius})) &&
                     (dy == $signed({1'b0, cfg.y_radius}));

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty && q_head.is_write)
      line_store[{q_head.ring, q_head.col}] <= q_head.pixel;
  end

  always_ff @(posedge clk) begin
    rd_data <= line_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    o_push     = 1'b0;
    o_entry.red          = pass[0] ? centre[0] : quo[0][7:0];
    o_entry.green        = pass[1] ? centre[1] : quo[1][7:0];
    o_entry.blue         = pass[2] ? centre[2] : quo[2][7:0];
    o_entry.last_of_run  = job.last_of_run;
    o_entry.end_of_frame = job.end_of_frame;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (!q_head.is_write) state_next = B_CENTRE;
        end
      end
      B_CENTRE: state_next = B_SCAN;
      B_SCAN:   if (scan_last) state_next = B_DRAIN;
      B_DRAIN:  state_next = B_PREP;
      B_PREP:   state_next = B_DIV;
      B_DIV:    if (step == 5'd15) state_next = B_OUT;
      B_OUT: begin
        if (!o_full) begin
          o_push     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cen_v  <= 1'b0;
      scan_v <= 1'b0;
    end else begin
      cen_v  <= (state == B_CENTRE);
      scan_v <= (state == B_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0]  v;
    logic [7:0]  d;
    logic [8:0]  rsh;
    logic        use_s;
    if (state == B_IDLE && !q_empty && !q_head.is_write) job <= q_head;
    if (state == B_CENTRE) begin
      dy <= -$signed({1'b0, cfg.y_radius});
      dx <= -$signed({1'b0, cfg.x_radius});
    end else if (state == B_SCAN) begin
      if (dx == $signed({1'b0, cfg.x_radius})) begin
        dx <= -$signed({1'b0, cfg.x_radius});
        dy <= dy + 4'sd1;
      end else begin
        dx <= dx + 4'sd1;
      end
    end
    if (state == B_DIV) step <= step + 5'd1;
    else step <= '0;
    for (int k = 0; k < 3; k++) begin
      v = rd_data[8*(2-k) +: 8];
      d = (v > centre[k]) ? v - centre[k] : centre[k] - v;
      if (cen_v) begin
        centre[k] <= v;
        sum[k]    <= '0;
        ssum[k]   <= '0;
        cnt[k]    <= '0;
      end else if (scan_v) begin
        sum[k] <= sum[k] + 16'(v);
        if ({1'b0, d} < cfg.sigma_threshold) begin
          ssum[k] <= ssum[k] + 16'(v);
          cnt[k]  <= cnt[k] + 8'd1;
        end
      end
      use_s = (cnt[k] != 8'd0) && (cnt[k] >= cfg.min_count);
      if (state == B_PREP) begin
        pass[k] <= !use_s && (neigh == 8'd0);
        quo[k]  <= use_s ? ssum[k] : sum[k] - 16'(centre[k]);
        dvs[k]  <= use_s ? cnt[k] : neigh;
        rem[k]  <= '0;
      end else if (state == B_DIV) begin
        rsh = {rem[k], quo[k][15]};
        if (rsh >= {1'b0, dvs[k]}) begin
          rem[k] <= 8'(rsh - {1'b0, dvs[k]});
          quo[k] <= {quo[k][14:0], 1'b1};
        end else begin
          rem[k] <= rsh[7:0];
          quo[k] <= {quo[k][14:0], 1'b0};
        end
      end
    end
  end

endmodule

// ===== src/sigma_mean_filter_rgb.sv =====
`timescale 1ns / 1ps
// Throughput: one window pixel read per cycle from the line store's single read port; the
// window engine takes a new job only once the current result has been pushed out.
// Pixel writes are done by the window engine while it is idle, as it pops them from the queue.
// Reset: synchronous, active high; registers return to defaults, counters and queues clear.
// ----------------------------------------------------------------------------
// sigma_mean_filter_rgb
// RGB888 sigma mean filter with line stores and queue-style ports.
// ----------------------------------------------------------------------------
module sigma_mean_filter_rgb import smf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        last_of_run,
  output logic        end_of_frame
);

  cfg_t       cfg;
  logic       jq_push, jq_full, jq_pop, jq_empty;
  job_t       jq_entry, jq_head;
  logic       o_push, o_full;
  res_t       o_entry;
  res_t       res_q [4];
  logic [1:0] o_wptr, o_rptr;
  logic [2:0] o_count;

  smf_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .push, .full, .command,
    .in_red, .in_green, .in_blue, .cfg,
    .q_push(jq_push), .q_entry(jq_entry), .q_full(jq_full)
  );

  smf_job_queue u_jq (
    .clk, .rst, .wr(jq_push), .wr_entry(jq_entry), .q_full(jq_full),
    .rd(jq_pop), .q_empty(jq_empty), .head(jq_head)
  );

  smf_back u_back (
    .clk, .rst, .cfg, .q_empty(jq_empty), .q_head(jq_head), .q_pop(jq_pop),
    .o_full, .o_push, .o_entry
  );

  assign o_full       = (o_count == 3'd4);
  assign empty        = (o_count == 3'd0);
  assign out_red      = res_q[o_rptr].red;
  assign out_green    = res_q[o_rptr].green;
  assign out_blue     = res_q[o_rptr].blue;
  assign last_of_run  = res_q[o_rptr].last_of_run;
  assign end_of_frame = res_q[o_rptr].end_of_frame;

  always_ff @(posedge clk) begin
    if (o_push && !o_full) res_q[o_wptr] <= o_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wptr  <= '0;
      o_rptr  <= '0;
      o_count <= '0;
    end else begin
      if (o_push && !o_full) o_wptr <= o_wptr + 2'd1;
      if (pop && !empty) o_rptr <= o_rptr + 2'd1;
      o_count <= o_count + 3'(o_push && !o_full) - 3'(pop && !empty);
    end
  end

endmodule

// ===== src/smf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks on the filter, bound to the top level.
// ----------------------------------------------------------------------------
module smf_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red,
  input logic       last_of_run,
  input logic       end_of_frame
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input stalled after reset");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> last_of_run)
    else $error("frame end result not last of its transaction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_red))
    else $error("waiting result changed");

endmodule

bind sigma_mean_filter_rgb smf_checker u_smf_checker (
  .clk, .rst, .full, .empty, .pop, .out_red, .last_of_run, .end_of_frame
);

// ===== tb/sigma_mean_filter_rgb_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_mean_filter_rgb_tb
// Self-checking bench for the RGB sigma mean filter. A behavioural copy of the
// window filter predicts every output pixel. Each popped transaction is
// checked field by field, in order, against those predictions. Directed
// frames cover pass-through, flushes and the register extremes. Random frames
// follow under four phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module sigma_mean_filter_rgb_tb;
  import smf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic command = 1'b0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic last_of_run, end_of_frame;

  sigma_mean_filter_rgb dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state as seen from outside
  logic [23:0] pix_mem [RingRows*MaxWidth];
  int unsigned wr_col, wr_row, rd_col, rd_row;
  int unsigned fw, fh, xr, yr, mc, sig;
  res_t pending_px[$];
  int errors = 0, items = 0, results = 0, eof_seen = 0;
  int send_idle_pct = 0, pop_stall_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic int unsigned clampi(input int v, input int unsigned lim);
    if (v < 0) return 0;
    if (v >= int'(lim)) return lim - 1;
    return v;
  endfunction

  function automatic bit px_ready();
    int unsigned nr, nc;
    if (rd_row >= fh) return 0;
    nr = rd_row + yr;
    if (nr > fh - 1) nr = fh - 1;
    nc = rd_col + xr;
    if (nc > fw - 1) nc = fw - 1;
    return nr < wr_row || (nr == wr_row && nc < wr_col);
  endfunction

  function automatic logic [23:0] px_at(input int unsigned r, input int unsigned c);
    return pix_mem[(r % RingRows) * MaxWidth + (c % MaxWidth)];
  endfunction

  function automatic logic [7:0] sigma_mean(input int sh);
    int unsigned neigh, centre, sum, ssum, cnt, r, c, v, d;
    neigh = (2*xr+1) * (2*yr+1) - 1;
    centre = (px_at(rd_row, rd_col) >> sh) & 8'hFF;
    sum = 0; ssum = 0; cnt = 0;
    for (int dy = -int'(yr); dy <= int'(yr); dy++) begin
      r = clampi(int'(rd_row) + dy, fh);
      for (int dx = -int'(xr); dx <= int'(xr); dx++) begin
        c = clampi(int'(rd_col) + dx, fw);
        v = (px_at(r, c) >> sh) & 8'hFF;
        d = v > centre ? v - centre : centre - v;
        sum += v;
        if (d < sig) begin
          ssum += v;
          cnt++;
        end
      end
    end
    if (cnt != 0 && cnt >= mc) return 8'(ssum / cnt);
    if (neigh == 0) return 8'(centre);
    return 8'((sum - centre) / neigh);
  endfunction

  function automatic res_t next_px();
    res_t p;
    bit lastpx;
    lastpx = rd_row == fh - 1 && rd_col == fw - 1;
    p.red = sigma_mean(16);
    p.green = sigma_mean(8);
    p.blue = sigma_mean(0);
    p.last_of_run = 1'b0;
    p.end_of_frame = lastpx;
    if (lastpx) begin
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    end else begin
      rd_col++;
      if (rd_col >= fw) begin
        rd_col = 0;
        rd_row++;
      end
    end
    return p;
  endfunction

  function automatic void predict_px(input cmd_e cmd, input logic [23:0] px);
    res_t batch[$];
    if (cmd == CMD_PUSH) begin
      if (wr_row >= fh) return;
      pix_mem[(wr_row % RingRows) * MaxWidth + wr_col] = px;
      wr_col++;
      if (wr_col >= fw) begin
        wr_col = 0;
        wr_row++;
      end
      while (batch.size() < 8 && px_ready()) batch.push_back(next_px());
    end else if (px_ready()) begin
      batch.push_back(next_px());
    end
    if (batch.size() > 0) batch[batch.size()-1].last_of_run = 1'b1;
    foreach (batch[i]) pending_px.push_back(batch[i]);
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [7:0] r, g, b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (full);
    predict_px(cmd, {r, g, b});
    items++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_px.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    int unsigned v;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 11'(val);
    @(posedge clk);
    v = val & 11'h7FF;
    case (idx)
      REG_FRAME_WIDTH:  fw = v < 1 ? 1 : (v > MaxWidth ? MaxWidth : v);
      REG_FRAME_HEIGHT: fh = v < 1 ? 1 : (v > MaxHeight ? MaxHeight : v);
      REG_X_RADIUS:     xr = (v & 7) > MaxRadius ? MaxRadius : (v & 7);
      REG_Y_RADIUS:     yr = (v & 7) > MaxRadius ? MaxRadius : (v & 7);
      REG_MIN_COUNT:    mc = v & 8'hFF;
      REG_SIGMA:        sig = v & 9'h1FF;
      default: ;
    endcase
    wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
  endtask

  task automatic setup(input int unsigned w, h, rx, ry, m, s);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_X_RADIUS, rx);
    write_reg(REG_Y_RADIUS, ry);
    write_reg(REG_MIN_COUNT, m);
    write_reg(REG_SIGMA, s);
    cfg_write <= 1'b0;
  endtask

  task automatic flush_all();
    while (px_ready()) send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // 1x1 window, nothing close: centre passes straight through
  task automatic test_passthrough();
    logic [7:0] pat [8] = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h01, 8'h80};
    setup(4, 2, 0, 0, 225, 0);
    foreach (pat[i]) send_item(CMD_PUSH, pat[i], ~pat[i], pat[(i+3)%8]);
  endtask

  // radius beyond the frame, everything close; tail emptied by flushes
  task automatic test_flush_tail();
    setup(3, 3, 7, 7, 0, 256);
    for (int i = 0; i < 9; i++) send_item(CMD_PUSH, 8'(i * 31), 8'(255 - i), 8'(i * 7));
    send_item(CMD_PUSH, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PUSH, 8'h12, 8'h34, 8'h56);
  endtask

  task automatic test_wide_row();
    setup(1024, 1, 1, 0, 1, 25);
    for (int i = 0; i < 10; i++)
      send_item(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    setup(2047, 0, 1, 1, 3, 40);
    for (int i = 0; i < 4; i++)
      send_item(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_frame();
    int unsigned w, h, rx, ry, base;
    w = $urandom_range(1, 12);
    h = $urandom_range(1, 8);
    rx = $urandom_range(9) == 0 ? 7 : $urandom_range(3);
    ry = $urandom_range(9) == 0 ? 7 : $urandom_range(3);
    setup(w, h, rx, ry, $urandom_range(9) == 0 ? 225 : $urandom_range(10),
          $urandom_range(9) == 0 ? 256 : $urandom_range(60));
    base = $urandom_range(255);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(15) == 0)
        send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0)
        send_item(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_item(CMD_PUSH, 8'(base + $urandom_range(30)), 8'(base + $urandom_range(30)),
                  8'(base - $urandom_range(30)));
    end
    if ($urandom_range(3) == 0 && px_ready())
      send_item(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(7) != 0) flush_all();
    if ($urandom_range(3) == 0)
      send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int upto);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    while (items < upto) random_frame();
  endtask

  always @(posedge clk) begin
    pop <= pop_stall_pct == 0 || $urandom_range(99) >= pop_stall_pct;
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected transaction, red", out_red, -1);
      end else begin
        res_t e;
        e = pending_px.pop_front();
        if (out_red !== e.red) report_mismatch("out_red", out_red, e.red);
        if (out_green !== e.green) report_mismatch("out_green", out_green, e.green);
        if (out_blue !== e.blue) report_mismatch("out_blue", out_blue, e.blue);
        if (last_of_run !== e.last_of_run)
          report_mismatch("last_of_run", last_of_run, e.last_of_run);
        if (end_of_frame !== e.end_of_frame)
          report_mismatch("end_of_frame", end_of_frame, e.end_of_frame);
        if (e.end_of_frame) eof_seen++;
      end
      results++;
    end
  end

  initial begin
    fw = 1024; fh = 1024; xr = 1; yr = 1; mc = 1; sig = 25;
    wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_flush_tail();
    test_wide_row();
    test_random(0, 0, 130);
    test_random(70, 0, 230);
    test_random(0, 70, 330);
    test_random(32, 32, 430);
    drain();
    $display("%0d input transactions, %0d output pixels, %0d completed frames",
             items, results, eof_seen);
    $display("window radii 0..7, sizes 1..1024, four idling phases");
    if (errors == 0 && pending_px.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smf_pkg.sv
src/smf_front.sv
src/smf_job_queue.sv
src/smf_back.sv
src/sigma_mean_filter_rgb.sv
src/smf_checker.sv
tb/sigma_mean_filter_rgb_tb.sv
